// ----- sv/hsvba_pkg.sv -----
// ----------------------------------------------------------------------------
// HSV brightness adjust package
// Shared widths, constants, configuration register indexes and pipeline
// data types.
// ----------------------------------------------------------------------------
package hsvba_pkg;

    localparam int CHAN_W       = 16;
    localparam int VNEW_W       = CHAN_W + 1;
    localparam int GAIN_W       = 16;
    localparam int BIAS_W       = 10;
    localparam int PROD_W       = GAIN_W + CHAN_W;
    localparam int GAIN_FRAC    = 12;
    localparam int BIAS_SHIFT   = 8;
    localparam int SUM_W        = 22;
    localparam int DIVIDEND_W   = CHAN_W + VNEW_W;
    localparam int DIV_STEPS    = VNEW_W;
    localparam int LANES        = 3;
    localparam int FRONT_STAGES = 4;
    localparam int NUM_STAGES   = FRONT_STAGES + DIV_STEPS + 1;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 16;

    localparam logic [GAIN_W-1:0] GAIN_ONE   = GAIN_W'(4096);
    localparam logic [BIAS_W-1:0] BIAS_ZERO  = '0;
    localparam logic [VNEW_W-1:0] FULL_SCALE = VNEW_W'(65536);

    localparam logic [CFG_IDX_W-1:0] CFG_GAIN = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BIAS = 1'b1;

    localparam int LANE_BLUE  = 0;
    localparam int LANE_GREEN = 1;
    localparam int LANE_RED   = 2;

    typedef struct packed {
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] alpha;
    } pix_t;

    typedef struct packed {
        pix_t              pix;
        logic [CHAN_W-1:0] vmax;
        logic [VNEW_W-1:0] vnew;
        logic              bypass;
    } side_t;

    typedef struct packed {
        logic [CHAN_W-1:0] rem;
        logic [VNEW_W-1:0] low;
    } div_t;

    typedef div_t [LANES-1:0] lanes_t;

endpackage

// ----- sv/hsvba_front.sv -----
// ----------------------------------------------------------------------------
// HSV brightness adjust front end
// Four pipeline stages: maximum of the colour channels, gain multiply,
// bias add with clamp, and the per-channel products that feed the divider.
// ----------------------------------------------------------------------------
module hsvba_front (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [hsvba_pkg::FRONT_STAGES-1:0] en,
    input  logic                            in_valid,
    input  hsvba_pkg::pix_t                 in_pix,
    input  logic [hsvba_pkg::GAIN_W-1:0]    gain,
    input  logic [hsvba_pkg::BIAS_W-1:0]    bias,
    output logic [hsvba_pkg::FRONT_STAGES-1:0] valid,
    output hsvba_pkg::side_t                out_side,
    output hsvba_pkg::lanes_t               out_lanes
);
    import hsvba_pkg::*;

    logic [FRONT_STAGES-1:0] valid_reg;
    logic [FRONT_STAGES-1:0] valid_next;

    pix_t              pix1_reg;
    logic [CHAN_W-1:0] max1_reg;
    logic              byp1_reg;
    logic [CHAN_W-1:0] max_next;
    logic              byp_next;

    pix_t              pix2_reg;
    logic [CHAN_W-1:0] max2_reg;
    logic              byp2_reg;
    logic [PROD_W-1:0] prod2_reg;
    logic [PROD_W-1:0] prod_next;

    pix_t              pix3_reg;
    logic [CHAN_W-1:0] max3_reg;
    logic              byp3_reg;
    logic [VNEW_W-1:0] vnew3_reg;
    logic signed [SUM_W-1:0] sum_next;
    logic [VNEW_W-1:0] vnew_next;

    side_t             side4_reg;
    lanes_t            lanes4_reg;
    lanes_t            lanes_next;
    logic [DIVIDEND_W-1:0] dividend [LANES];
    logic [CHAN_W-1:0] chan [LANES];

    always_comb
    begin
        max_next = in_pix.red;
        if (in_pix.green > max_next)
        begin
            max_next = in_pix.green;
        end
        if (in_pix.blue > max_next)
        begin
            max_next = in_pix.blue;
        end
        byp_next = (gain == GAIN_ONE) && (bias == BIAS_ZERO);
    end

    assign prod_next = {{GAIN_W{1'b0}}, max1_reg} * {{CHAN_W{1'b0}}, gain};

    always_comb
    begin
        sum_next = $signed({2'b00, prod2_reg[PROD_W-1:GAIN_FRAC]})
                 + $signed({{(SUM_W-BIAS_W-BIAS_SHIFT){bias[BIAS_W-1]}}, bias,
                            {BIAS_SHIFT{1'b0}}});
        if (sum_next < 0)
        begin
            vnew_next = '0;
        end
        else if (sum_next > $signed({{(SUM_W-VNEW_W){1'b0}}, FULL_SCALE}))
        begin
            vnew_next = FULL_SCALE;
        end
        else
        begin
            vnew_next = sum_next[VNEW_W-1:0];
        end
    end

    always_comb
    begin
        chan[LANE_BLUE]  = pix3_reg.blue;
        chan[LANE_GREEN] = pix3_reg.green;
        chan[LANE_RED]   = pix3_reg.red;
        for (int i = 0; i < LANES; i++)
        begin
            dividend[i] = {{VNEW_W{1'b0}}, chan[i]} * {{CHAN_W{1'b0}}, vnew3_reg};
            lanes_next[i].rem = dividend[i][DIVIDEND_W-1:VNEW_W];
            lanes_next[i].low = dividend[i][VNEW_W-1:0];
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (en[0])
        begin
            valid_next[0] = in_valid;
        end
        for (int s = 1; s < FRONT_STAGES; s++)
        begin
            if (en[s])
            begin
                valid_next[s] = valid_reg[s-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            pix1_reg <= in_pix;
            max1_reg <= max_next;
            byp1_reg <= byp_next;
        end
        if (en[1])
        begin
            pix2_reg  <= pix1_reg;
            max2_reg  <= max1_reg;
            byp2_reg  <= byp1_reg;
            prod2_reg <= prod_next;
        end
        if (en[2])
        begin
            pix3_reg  <= pix2_reg;
            max3_reg  <= max2_reg;
            byp3_reg  <= byp2_reg;
            vnew3_reg <= vnew_next;
        end
        if (en[3])
        begin
            side4_reg.pix    <= pix3_reg;
            side4_reg.vmax   <= max3_reg;
            side4_reg.vnew   <= vnew3_reg;
            side4_reg.bypass <= byp3_reg;
            lanes4_reg       <= lanes_next;
        end
    end

    assign valid     = valid_reg;
    assign out_side  = side4_reg;
    assign out_lanes = lanes4_reg;

endmodule

// ----- sv/hsvba_div_step.sv -----
// ----------------------------------------------------------------------------
// HSV brightness adjust divider step
// One restoring division stage for the three colour lanes, producing one
// quotient bit per lane, with the pixel sideband carried alongside.
// ----------------------------------------------------------------------------
module hsvba_div_step (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  hsvba_pkg::side_t   in_side,
    input  hsvba_pkg::lanes_t  in_lanes,
    output logic               out_valid,
    output hsvba_pkg::side_t   out_side,
    output hsvba_pkg::lanes_t  out_lanes
);
    import hsvba_pkg::*;

    logic              valid_reg;
    side_t             side_reg;
    lanes_t            lanes_reg;
    lanes_t            lanes_next;
    logic [VNEW_W-1:0] trial [LANES];
    logic [VNEW_W-1:0] diff  [LANES];
    logic              fits  [LANES];

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            trial[i] = {in_lanes[i].rem, in_lanes[i].low[VNEW_W-1]};
            diff[i]  = trial[i] - {1'b0, in_side.vmax};
            fits[i]  = trial[i] >= {1'b0, in_side.vmax};
            lanes_next[i].rem = fits[i] ? diff[i][CHAN_W-1:0] : trial[i][CHAN_W-1:0];
            lanes_next[i].low = {in_lanes[i].low[VNEW_W-2:0], fits[i]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg  <= in_side;
            lanes_reg <= lanes_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_side  = side_reg;
    assign out_lanes = lanes_reg;

endmodule

// ----- sv/hsvba_back.sv -----
// ----------------------------------------------------------------------------
// HSV brightness adjust back end
// Selects the quotient, the new value for a black pixel or the untouched
// input, applies the channel and alpha limits, and holds the output register.
// ----------------------------------------------------------------------------
module hsvba_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  hsvba_pkg::side_t            in_side,
    input  hsvba_pkg::lanes_t           in_lanes,
    output logic                        out_valid,
    output hsvba_pkg::pix_t             out_pix
);
    import hsvba_pkg::*;

    logic              valid_reg;
    pix_t              pix_reg;
    pix_t              pix_next;
    logic [CHAN_W-1:0] chan   [LANES];
    logic [VNEW_W-1:0] pick   [LANES];
    logic [CHAN_W-1:0] result [LANES];

    always_comb
    begin
        chan[LANE_BLUE]  = in_side.pix.blue;
        chan[LANE_GREEN] = in_side.pix.green;
        chan[LANE_RED]   = in_side.pix.red;
        for (int i = 0; i < LANES; i++)
        begin
            if (in_side.bypass)
            begin
                pick[i] = {1'b0, chan[i]};
            end
            else if (in_side.vmax == '0)
            begin
                pick[i] = in_side.vnew;
            end
            else
            begin
                pick[i] = in_lanes[i].low;
            end
            result[i] = pick[i][VNEW_W-1] ? {CHAN_W{1'b1}} : pick[i][CHAN_W-1:0];
            if (!in_side.bypass && (result[i] > in_side.pix.alpha))
            begin
                result[i] = in_side.pix.alpha;
            end
        end
        pix_next.blue  = result[LANE_BLUE];
        pix_next.green = result[LANE_GREEN];
        pix_next.red   = result[LANE_RED];
        pix_next.alpha = in_side.pix.alpha;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pix_reg <= pix_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_pix   = pix_reg;

endmodule

// ----- sv/hsv_brightness_adjust_unit.sv -----
// ----------------------------------------------------------------------------
// HSV brightness adjust unit
// Rescales the HSV value of premultiplied 16-bit BGRA pixels by a gain and
// a bias, keeping hue and saturation, one pixel per clock unless stalled.
// ----------------------------------------------------------------------------
// Pixels enter on the input channel (in_valid, in_stall) and leave on the
// output channel (out_valid, out_stall); a transfer happens on a rising edge
// with valid high and stall low. Each pixel passes 22 register stages: the
// value maximum, the gain multiply, the bias clamp, the channel products,
// seventeen restoring divider stages that each resolve one quotient bit, and
// the output register. One pixel can be taken every cycle while the output
// is not stalled.
// Each stage advances whenever the stage after it is empty or advancing, so
// a stall at the output first fills the empty stages and only then stalls
// the input; nothing is dropped or repeated.
// Gain and bias are written through cfg_we, cfg_index and cfg_data only while
// the pipeline is empty, a rule for the user that the block does not enforce.
// Reset empties the pipeline and sets gain to 1.0 and bias to zero, so pixels pass unchanged.
// ----------------------------------------------------------------------------
module hsv_brightness_adjust_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [hsvba_pkg::CHAN_W-1:0]       blue_in,
    input  logic [hsvba_pkg::CHAN_W-1:0]       green_in,
    input  logic [hsvba_pkg::CHAN_W-1:0]       red_in,
    input  logic [hsvba_pkg::CHAN_W-1:0]       alpha_in,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [hsvba_pkg::CHAN_W-1:0]       blue_out,
    output logic [hsvba_pkg::CHAN_W-1:0]       green_out,
    output logic [hsvba_pkg::CHAN_W-1:0]       red_out,
    output logic [hsvba_pkg::CHAN_W-1:0]       alpha_out,
    input  logic                               cfg_we,
    input  logic [hsvba_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [hsvba_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import hsvba_pkg::*;

    logic [GAIN_W-1:0] gain_reg;
    logic [BIAS_W-1:0] bias_reg;
    logic [GAIN_W-1:0] gain_next;
    logic [BIAS_W-1:0] bias_next;

    logic [NUM_STAGES-1:0]   en;
    logic [NUM_STAGES-1:0]   stage_valid;
    logic [FRONT_STAGES-1:0] front_valid;
    logic [DIV_STEPS:0]      div_valid;
    side_t                   div_side  [DIV_STEPS+1];
    lanes_t                  div_lanes [DIV_STEPS+1];
    pix_t                    in_pix;
    pix_t                    out_pix;
    logic                    back_valid;

    always_comb
    begin
        gain_next = gain_reg;
        bias_next = bias_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_GAIN: gain_next = cfg_data[GAIN_W-1:0];
                CFG_BIAS: bias_next = cfg_data[BIAS_W-1:0];
                default:
                begin
                    gain_next = gain_reg;
                    bias_next = bias_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg <= GAIN_ONE;
            bias_reg <= BIAS_ZERO;
        end
        else
        begin
            gain_reg <= gain_next;
            bias_reg <= bias_next;
        end
    end

    assign stage_valid = {back_valid, div_valid[DIV_STEPS:1], front_valid};

    always_comb
    begin
        en[NUM_STAGES-1] = !stage_valid[NUM_STAGES-1] || !out_stall;
        for (int i = NUM_STAGES - 2; i >= 0; i--)
        begin
            en[i] = !stage_valid[i] || en[i+1];
        end
    end

    genvar s;

    assign in_stall = !en[0];

    assign in_pix.blue  = blue_in;
    assign in_pix.green = green_in;
    assign in_pix.red   = red_in;
    assign in_pix.alpha = alpha_in;

    hsvba_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en[FRONT_STAGES-1:0]),
        .in_valid  (in_valid),
        .in_pix    (in_pix),
        .gain      (gain_reg),
        .bias      (bias_reg),
        .valid     (front_valid),
        .out_side  (div_side[0]),
        .out_lanes (div_lanes[0])
    );

    assign div_valid[0] = front_valid[FRONT_STAGES-1];

    generate
        for (s = 0; s < DIV_STEPS; s++)
        begin : g_div
            hsvba_div_step u_step (
                .clk       (clk),
                .rst_n     (rst_n),
                .en        (en[FRONT_STAGES+s]),
                .in_valid  (div_valid[s]),
                .in_side   (div_side[s]),
                .in_lanes  (div_lanes[s]),
                .out_valid (div_valid[s+1]),
                .out_side  (div_side[s+1]),
                .out_lanes (div_lanes[s+1])
            );
        end
    endgenerate

    hsvba_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en[NUM_STAGES-1]),
        .in_valid  (div_valid[DIV_STEPS]),
        .in_side   (div_side[DIV_STEPS]),
        .in_lanes  (div_lanes[DIV_STEPS]),
        .out_valid (back_valid),
        .out_pix   (out_pix)
    );

    assign out_valid = back_valid;
    assign blue_out  = out_pix.blue;
    assign green_out = out_pix.green;
    assign red_out   = out_pix.red;
    assign alpha_out = out_pix.alpha;

    // An empty output register means every stage can move.
    assert property (@(posedge clk) disable iff (!rst_n) !out_valid |-> !in_stall)
        else $error("input stalled while the output register is empty");

    // A free output lets the whole pipeline advance.
    assert property (@(posedge clk) disable iff (!rst_n) !out_stall |-> !in_stall)
        else $error("input stalled while the output is not stalled");

    // A first stage that holds an item and cannot advance keeps it.
    assert property (@(posedge clk) disable iff (!rst_n)
                     (stage_valid[0] && !en[0]) |=> stage_valid[0])
        else $error("first stage lost a held item");

endmodule
